// ===== hdl/htbi_pkg.sv =====
package htbi_pkg;

    // Fixed-point constants of the interpolation
    localparam int Q14_ONE  = 16384;
    localparam int Q16_ONE  = 65536;
    localparam int Q16_HALF = 32768;
    localparam int Q16_FRAC = 16;

    // Tangent scaling: drop 8 bits before the tension multiply, 13 after
    localparam int TAN_PRE_SHIFT  = 8;
    localparam int TAN_POST_SHIFT = 13;
    // Tangent times basis is Q8 times Q16, brought back to Q16
    localparam int MH_SHIFT       = 8;

    // Configuration register format
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 1;

    // Internal widths that do not depend on the sample width
    localparam int K_W   = 17;  // 1.0 +/- tension or bias, signed
    localparam int TQ_W  = 17;  // position in Q16, below 2.0
    localparam int T2_W  = 18;  // t^2 in Q16
    localparam int T3_W  = 19;  // t^3 in Q16
    localparam int TSQ_W = 2 * TQ_W;
    localparam int TCU_W = T2_W + TQ_W;
    localparam int H_W   = 22;  // Hermite basis values, signed Q16

    // Register stages from input to output
    localparam int PIPE_DEPTH = 7;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TENSION = 1'b0,
        REG_BIAS    = 1'b1
    } cfg_reg_t;

endpackage

// ===== hdl/hermite_tension_bias_interpolator_unit.sv =====
// Cubic Hermite interpolator with tension and bias. Each input item carries
// four consecutive signed samples and a position in unsigned Q.POSITION_FRAC_BITS;
// the result is the interpolated sample, rounded half up and saturated to the
// sample range, with a clip flag in tuser. The datapath is a seven-stage
// register pipeline: one item enters every clock while the output side does not
// stall, each multiplier level holding one stage of its own. Every stage
// keeps its own valid bit and fills bubbles when the output side stalls, so a
// new item is taken whenever any stage is free. Tension and bias (signed Q2.14)
// are written through the cfg port; the user must do so only while no item is
// in flight, as the block does not enforce it. There is no read-back.
module hermite_tension_bias_interpolator_unit
    import htbi_pkg::*;
#(
    parameter int SAMPLE_WIDTH       = 16,
    parameter int POSITION_FRAC_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,

    // Input items
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // point_before, point_start, point_end, point_after, position, zero pad
    input  logic [((4*SAMPLE_WIDTH+POSITION_FRAC_BITS+1+7)/8)*8-1:0] s_tdata,

    // Result items
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // value, zero pad
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
    // clipped
    output logic [0:0]             m_tuser
);

    localparam int SW      = SAMPLE_WIDTH;
    localparam int POS_W   = POSITION_FRAC_BITS + 1;
    localparam int OUT_W   = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int D_W     = SW + 1;
    localparam int PROD_W  = D_W + K_W;
    localparam int S_W     = PROD_W + 1;
    localparam int SS_W    = S_W - TAN_PRE_SHIFT;
    localparam int MT_W    = SS_W + K_W;
    localparam int M_W     = MT_W - TAN_POST_SHIFT;
    localparam int PH_W    = SW + H_W;
    localparam int MH_W    = M_W + H_W;
    localparam int MHS_W   = MH_W - MH_SHIFT;
    localparam int ACC_W   = SW + 26;
    localparam int V_W     = ACC_W - Q16_FRAC;

    localparam logic [SW-1:0] VAL_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic [SW-1:0] VAL_MIN = {1'b1, {(SW-1){1'b0}}};

    // Configuration registers
    logic signed [CFG_W-1:0] tension_reg;
    logic signed [CFG_W-1:0] bias_reg;

    // Pipeline control
    logic [PIPE_DEPTH-1:0] v_reg;
    logic [PIPE_DEPTH-1:0] v_next;
    logic [PIPE_DEPTH-1:0] en;

    // Factors derived from the registers
    logic signed [K_W-1:0] bias_p;
    logic signed [K_W-1:0] bias_m;
    logic signed [K_W-1:0] ten_f;

    // Input fields
    logic signed [SW-1:0]  p0;
    logic signed [SW-1:0]  p1;
    logic signed [SW-1:0]  p2;
    logic signed [SW-1:0]  p3;
    logic [POS_W-1:0]      pos;
    logic [TQ_W-1:0]       tq;

    // Stage 1: differences and position
    logic signed [D_W-1:0]    d01_reg, d12_reg, d23_reg;
    logic signed [D_W-1:0]    d01_next, d12_next, d23_next;
    logic signed [SW-1:0]     p1_s1_reg, p2_s1_reg;
    logic [TQ_W-1:0]          tq_s1_reg;

    // Stage 2: bias products and t^2
    logic signed [PROD_W-1:0] pa0_reg, pb0_reg, pa1_reg, pb1_reg;
    logic signed [PROD_W-1:0] pa0_next, pb0_next, pa1_next, pb1_next;
    logic [TSQ_W-1:0]         tsq;
    logic [T2_W-1:0]          t2_s2_reg;
    logic [TQ_W-1:0]          tq_s2_reg;
    logic signed [SW-1:0]     p1_s2_reg, p2_s2_reg;

    // Stage 3: tension products and t^3
    logic signed [S_W-1:0]    s0, s1;
    logic signed [SS_W-1:0]   ss0, ss1;
    logic signed [MT_W-1:0]   mt0_reg, mt1_reg;
    logic signed [MT_W-1:0]   mt0_next, mt1_next;
    logic [TCU_W-1:0]         tcu;
    logic [T3_W-1:0]          t3_s3_reg;
    logic [T2_W-1:0]          t2_s3_reg;
    logic [TQ_W-1:0]          tq_s3_reg;
    logic signed [SW-1:0]     p1_s3_reg, p2_s3_reg;

    // Stage 4: tangents and basis
    logic signed [H_W-1:0]    e1, e2, e3;
    logic signed [M_W-1:0]    m0_reg, m1_reg;
    logic signed [H_W-1:0]    h00_reg, h10_reg, h11_reg, h01_reg;
    logic signed [H_W-1:0]    h00_next, h10_next, h11_next, h01_next;
    logic signed [SW-1:0]     p1_s4_reg, p2_s4_reg;

    // Stage 5: weighted terms
    logic signed [PH_W-1:0]   ph1_reg, ph2_reg;
    logic signed [PH_W-1:0]   ph1_next, ph2_next;
    logic signed [MH_W-1:0]   mh0_reg, mh1_reg;
    logic signed [MH_W-1:0]   mh0_next, mh1_next;

    // Stage 6: accumulation with rounding offset
    logic signed [MHS_W-1:0]  mhs0, mhs1;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    // Stage 7: saturation and output register
    logic signed [V_W-1:0]    vq;
    logic                     over;
    logic [SW-1:0]            value_reg;
    logic [SW-1:0]            value_next;
    logic                     clip_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tension_reg <= '0;
            bias_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_TENSION: tension_reg <= $signed(cfg_wdata);
                REG_BIAS:    bias_reg    <= $signed(cfg_wdata);
                default:     tension_reg <= tension_reg;
            endcase
        end
    end

    assign bias_p = K_W'(Q14_ONE) + K_W'(bias_reg);
    assign bias_m = K_W'(Q14_ONE) - K_W'(bias_reg);
    assign ten_f  = K_W'(Q14_ONE) - K_W'(tension_reg);

    // Advance a stage when it is empty or the next one advances
    always_comb
    begin
        en[PIPE_DEPTH-1] = !v_reg[PIPE_DEPTH-1] || m_tready;
        for (int k = PIPE_DEPTH - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
        v_next[0] = en[0] ? s_tvalid : v_reg[0];
        for (int k = 1; k < PIPE_DEPTH; k++)
        begin
            v_next[k] = en[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = v_reg[PIPE_DEPTH-1];
    assign m_tdata  = OUT_W'(value_reg);
    assign m_tuser  = clip_reg;

    // Unpack input fields
    assign p0  = $signed(s_tdata[0*SW +: SW]);
    assign p1  = $signed(s_tdata[1*SW +: SW]);
    assign p2  = $signed(s_tdata[2*SW +: SW]);
    assign p3  = $signed(s_tdata[3*SW +: SW]);
    assign pos = s_tdata[4*SW +: POS_W];

    // Bring position to Q16
    generate
        if (POSITION_FRAC_BITS >= Q16_FRAC)
        begin : g_pos_down
            assign tq = TQ_W'(pos >> (POSITION_FRAC_BITS - Q16_FRAC));
        end
        else
        begin : g_pos_up
            assign tq = TQ_W'(pos) << (Q16_FRAC - POSITION_FRAC_BITS);
        end
    endgenerate

    // Stage 1: form sample differences
    always_comb
    begin
        d01_next = D_W'(p1) - D_W'(p0);
        d12_next = D_W'(p2) - D_W'(p1);
        d23_next = D_W'(p3) - D_W'(p2);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d01_reg   <= d01_next;
            d12_reg   <= d12_next;
            d23_reg   <= d23_next;
            p1_s1_reg <= p1;
            p2_s1_reg <= p2;
            tq_s1_reg <= tq;
        end
    end

    // Stage 2: weight differences by bias, square the position
    always_comb
    begin
        pa0_next = PROD_W'(d01_reg) * PROD_W'(bias_p);
        pb0_next = PROD_W'(d12_reg) * PROD_W'(bias_m);
        pa1_next = PROD_W'(d12_reg) * PROD_W'(bias_p);
        pb1_next = PROD_W'(d23_reg) * PROD_W'(bias_m);
        tsq      = TSQ_W'(tq_s1_reg) * TSQ_W'(tq_s1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            pa0_reg   <= pa0_next;
            pb0_reg   <= pb0_next;
            pa1_reg   <= pa1_next;
            pb1_reg   <= pb1_next;
            t2_s2_reg <= tsq[Q16_FRAC +: T2_W];
            tq_s2_reg <= tq_s1_reg;
            p1_s2_reg <= p1_s1_reg;
            p2_s2_reg <= p2_s1_reg;
        end
    end

    // Stage 3: sum, drop low bits, scale by tension; cube the position
    always_comb
    begin
        s0       = S_W'(pa0_reg) + S_W'(pb0_reg);
        s1       = S_W'(pa1_reg) + S_W'(pb1_reg);
        ss0      = SS_W'(s0 >>> TAN_PRE_SHIFT);
        ss1      = SS_W'(s1 >>> TAN_PRE_SHIFT);
        mt0_next = MT_W'(ss0) * MT_W'(ten_f);
        mt1_next = MT_W'(ss1) * MT_W'(ten_f);
        tcu      = TCU_W'(t2_s2_reg) * TCU_W'(tq_s2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            mt0_reg   <= mt0_next;
            mt1_reg   <= mt1_next;
            t3_s3_reg <= tcu[Q16_FRAC +: T3_W];
            t2_s3_reg <= t2_s2_reg;
            tq_s3_reg <= tq_s2_reg;
            p1_s3_reg <= p1_s2_reg;
            p2_s3_reg <= p2_s2_reg;
        end
    end

    // Stage 4: evaluate the Hermite basis
    always_comb
    begin
        e1       = $signed(H_W'(tq_s3_reg));
        e2       = $signed(H_W'(t2_s3_reg));
        e3       = $signed(H_W'(t3_s3_reg));
        h00_next = (e3 <<< 1) - (e2 <<< 1) - e2 + H_W'(Q16_ONE);
        h10_next = e3 - (e2 <<< 1) + e1;
        h11_next = e3 - e2;
        h01_next = (e2 <<< 1) + e2 - (e3 <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            m0_reg    <= M_W'(mt0_reg >>> TAN_POST_SHIFT);
            m1_reg    <= M_W'(mt1_reg >>> TAN_POST_SHIFT);
            h00_reg   <= h00_next;
            h10_reg   <= h10_next;
            h11_reg   <= h11_next;
            h01_reg   <= h01_next;
            p1_s4_reg <= p1_s3_reg;
            p2_s4_reg <= p2_s3_reg;
        end
    end

    // Stage 5: weight samples and tangents by the basis
    always_comb
    begin
        ph1_next = PH_W'(p1_s4_reg) * PH_W'(h00_reg);
        ph2_next = PH_W'(p2_s4_reg) * PH_W'(h01_reg);
        mh0_next = MH_W'(m0_reg) * MH_W'(h10_reg);
        mh1_next = MH_W'(m1_reg) * MH_W'(h11_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            ph1_reg <= ph1_next;
            ph2_reg <= ph2_next;
            mh0_reg <= mh0_next;
            mh1_reg <= mh1_next;
        end
    end

    // Stage 6: accumulate in Q16 with the half-LSB rounding offset
    always_comb
    begin
        mhs0     = MHS_W'(mh0_reg >>> MH_SHIFT);
        mhs1     = MHS_W'(mh1_reg >>> MH_SHIFT);
        acc_next = ACC_W'(ph1_reg) + ACC_W'(ph2_reg) + ACC_W'(mhs0) + ACC_W'(mhs1)
                 + ACC_W'(Q16_HALF);
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            acc_reg <= acc_next;
        end
    end

    // Stage 7: drop the fraction and saturate to the sample range
    always_comb
    begin
        vq   = V_W'(acc_reg >>> Q16_FRAC);
        over = (vq[V_W-1:SW-1] != {(V_W-SW+1){vq[V_W-1]}});
        if (over)
        begin
            value_next = vq[V_W-1] ? VAL_MIN : VAL_MAX;
        end
        else
        begin
            value_next = vq[SW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            value_reg <= value_next;
            clip_reg  <= over;
        end
    end

`ifndef ASSERT_OFF
    // A clipped result sits at one of the range limits
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (value_reg == VAL_MAX || value_reg == VAL_MIN))
        else $error("clipped result not at a range limit");

    // Input is refused only when every stage holds an item
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&v_reg))
        else $error("input stalled with a free pipeline stage");

    // Items in flight change only by accepted inputs and delivered results
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> ($countones(v_reg) == $past($countones(v_reg))
            + $past(int'(s_tvalid && s_tready)) - $past(int'(m_tvalid && m_tready))))
        else $error("item lost or duplicated in the pipeline");
`endif

endmodule
